FILE: design/wfpid_pkg.sv
// Shared types, constants and tables of the wall-following PID steering core.
// No dependencies; the core and the register file refer to it by scoped names.
`default_nettype none

package wfpid_pkg;

   // Parameter defaults
   localparam int MAX_SAMPLES_DEF    = 2048;
   localparam int CORDIC_STEPS_DEF   = 16;
   localparam int GAIN_FRAC_BITS_DEF = 24;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address is 4 * index)
   localparam logic [2:0] REG_INDEX_NEAR    = 3'd0;
   localparam logic [2:0] REG_INDEX_FAR     = 3'd1;
   localparam logic [2:0] REG_DESIRED_DIST  = 3'd2;
   localparam logic [2:0] REG_LOOKAHEAD     = 3'd3;
   localparam logic [2:0] REG_GAIN_P        = 3'd4;
   localparam logic [2:0] REG_GAIN_I        = 3'd5;
   localparam logic [2:0] REG_GAIN_D        = 3'd6;

   // Register reset values
   localparam logic [10:0] INDEX_NEAR_RST = 11'd720;
   localparam logic [10:0] INDEX_FAR_RST  = 11'd570;
   localparam logic [15:0] DESIRED_RST    = 16'd700;
   localparam logic [15:0] LOOKAHEAD_RST  = 16'd400;
   localparam logic [27:0] GAIN_P_RST     = 28'd41943040;
   localparam logic [27:0] GAIN_I_RST     = 28'd1678;
   localparam logic [27:0] GAIN_D_RST     = 28'd12582912;

   // Fixed-point constants
   localparam logic [15:0] SIN_THETA_Q16 = 16'd39896;
   localparam logic [15:0] COS_THETA_Q16 = 16'd51993;
   localparam logic [31:0] INV_GAIN_Q30  = 32'd652032874;
   localparam logic [9:0]  DIVISOR       = 10'd1000;
   // ceil(2^36 / 1000): exact quotient for any dividend below 2^26
   localparam logic [26:0] RECIP_1000    = 27'd68719477;
   localparam int          RECIP_SHIFT   = 36;
   localparam logic [18:0] SLOW_LIMIT    = 19'd5719;
   localparam logic [18:0] MID_LIMIT     = 19'd11438;
   localparam logic [10:0] SPEED_FAST    = 11'd1500;
   localparam logic [10:0] SPEED_MID     = 11'd1000;
   localparam logic [10:0] SPEED_SLOW    = 11'd500;

   // PID term select
   localparam logic [1:0] TERM_P = 2'd0;
   localparam logic [1:0] TERM_I = 2'd1;
   localparam logic [1:0] TERM_D = 2'd2;

   typedef struct packed {
      logic [10:0] index_near;
      logic [10:0] index_far;
      logic [15:0] desired_distance_mm;
      logic [15:0] lookahead_mm;
      logic [27:0] gain_p;
      logic [27:0] gain_i;
      logic [27:0] gain_d;
   } cfg_type;

   // atan(2^-i) in Q24 radians
   function automatic logic [23:0] atan_q24(input logic [4:0] idx);
      logic [23:0] val;
      unique case (idx)
         5'd0:  val = 24'd13176795;
         5'd1:  val = 24'd7778716;
         5'd2:  val = 24'd4110060;
         5'd3:  val = 24'd2086331;
         5'd4:  val = 24'd1047214;
         5'd5:  val = 24'd524117;
         5'd6:  val = 24'd262123;
         5'd7:  val = 24'd131069;
         5'd8:  val = 24'd65536;
         5'd9:  val = 24'd32768;
         5'd10: val = 24'd16384;
         5'd11: val = 24'd8192;
         5'd12: val = 24'd4096;
         5'd13: val = 24'd2048;
         5'd14: val = 24'd1024;
         5'd15: val = 24'd512;
         5'd16: val = 24'd256;
         5'd17: val = 24'd128;
         5'd18: val = 24'd64;
         5'd19: val = 24'd32;
         5'd20: val = 24'd16;
         5'd21: val = 24'd8;
         5'd22: val = 24'd4;
         5'd23: val = 24'd2;
         default: val = 24'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: design/wfpid_req_if.sv
// Input channel: one lidar range sample per item.
// No dependencies.
`default_nettype none

interface wfpid_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] range_mm;
   logic        scan_last;

   modport source (output valid, output range_mm, output scan_last, input ready);
   modport sink   (input valid, input range_mm, input scan_last, output ready);
endinterface

`default_nettype wire

FILE: design/wfpid_rsp_if.sv
// Result channel: steering angle, speed tier and error per scan.
// No dependencies.
`default_nettype none

interface wfpid_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [18:0] steering_rad;
   logic        [10:0] speed_mm_s;
   logic signed [17:0] error_mm;

   modport source (output valid, output steering_rad, output speed_mm_s,
                   output error_mm, input ready);
   modport sink   (input valid, input steering_rad, input speed_mm_s,
                   input error_mm, output ready);
endinterface

`default_nettype wire

FILE: design/wall_follow_pid_steering_core.sv
// Wall-following PID steering core: sample capture, CORDIC and PID sequencer.
// Depends on wfpid_pkg, wfpid_req_if, wfpid_rsp_if and wfpid_csr.
// Other samples: one per cycle. A scan end gives its item after acceptance, two CORDIC
// passes and three PID terms (each with a 4-step /1000), sooner when both ranges are
// zero or a term caps early; ready again in the cycle that the item is given.
// Last step waits while the previous item is pending. Sync reset: defaults, state cleared.
`default_nettype none

module wall_follow_pid_steering_core #(
   parameter int MAX_SAMPLES    = wfpid_pkg::MAX_SAMPLES_DEF,
   parameter int CORDIC_STEPS   = wfpid_pkg::CORDIC_STEPS_DEF,
   parameter int GAIN_FRAC_BITS = wfpid_pkg::GAIN_FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   wfpid_req_if.sink                             req_ch,
   wfpid_rsp_if.source                           rsp_ch,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [wfpid_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [wfpid_pkg::CSR_DATA_W-1:0] pwdata,
   output      logic [wfpid_pkg::CSR_DATA_W-1:0] prdata,
   output      logic                             pready
);

   localparam int CNT_W = $clog2(MAX_SAMPLES);
   localparam int CMP_W = (CNT_W > 11) ? CNT_W : 11;

   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_MUL_X    = 16'h0002,
      ST_MUL_Y    = 16'h0004,
      ST_VEC_INIT = 16'h0008,
      ST_VEC      = 16'h0010,
      ST_ROT_INIT = 16'h0020,
      ST_ROT      = 16'h0040,
      ST_PROJ_C   = 16'h0080,
      ST_PROJ_S   = 16'h0100,
      ST_ERR      = 16'h0200,
      ST_TERM_HI  = 16'h0400,
      ST_TERM_LO  = 16'h0800,
      ST_TERM_SUM = 16'h1000,
      ST_DIV      = 16'h2000,
      ST_TERM_FIN = 16'h4000,
      ST_OUT      = 16'h8000
   } state_type;

   wfpid_pkg::cfg_type cfg;

   wfpid_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff;
   logic [15:0]          range_near_ff, range_far_ff;
   logic signed [17:0]   last_error_ff;
   logic signed [39:0]   error_sum_ff;
   logic signed [17:0]   e_ff;
   logic signed [18:0]   diff_ff;
   logic signed [50:0]   prod_ff;
   logic signed [37:0]   x_ff, y_ff;
   logic signed [26:0]   z_ff;
   logic [4:0]           step_ff;
   logic signed [51:0]   acc_ff;
   logic [1:0]           term_ff;
   logic                 neg_ff, over_ff;
   logic [48:0]          hi_ff;
   logic [63:0]          quot_ff;
   logic [9:0]           rem_ff;
   logic [1:0]           chunk_ff;
   logic signed [44:0]   steer_ff;
   logic                 rsp_valid_ff;
   logic signed [18:0]   rsp_steer_ff;
   logic [10:0]          rsp_speed_ff;
   logic signed [17:0]   rsp_error_ff;

   // input handshake: samples taken only while the sequencer is idle
   logic req_fire;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // result register free when empty or being taken this cycle
   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.steering_rad = rsp_steer_ff;
   assign rsp_ch.speed_mm_s   = rsp_speed_ff;
   assign rsp_ch.error_mm     = rsp_error_ff;

   // sample index compare and wrap
   logic [CMP_W-1:0] count_ext;
   logic             hit_near, hit_far, count_wrap;
   assign count_ext  = CMP_W'(count_ff);
   assign hit_near   = count_ext == CMP_W'(cfg.index_near);
   assign hit_far    = count_ext == CMP_W'(cfg.index_far);
   assign count_wrap = (32'(count_ff) + 32'd1) >= 32'(MAX_SAMPLES);

   // PID term operand and magnitude
   logic signed [39:0] term_val;
   logic [39:0]        term_mag;
   logic [27:0]        term_gain;
   always_comb begin
      unique case (term_ff)
         wfpid_pkg::TERM_P: begin
            term_val  = 40'(e_ff);
            term_gain = cfg.gain_p;
         end
         wfpid_pkg::TERM_I: begin
            term_val  = error_sum_ff;
            term_gain = cfg.gain_i;
         end
         default: begin
            term_val  = 40'(diff_ff);
            term_gain = cfg.gain_d;
         end
      endcase
      term_mag = term_val[39] ? 40'(-term_val) : 40'(term_val);
   end

   // divide by 1000 operand: remainder so far and the next 16 dividend bits
   logic [25:0] div_num;
   assign div_num = {rem_ff, quot_ff[63:48]};

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_X: begin
            mul_a = $signed({17'd0, range_far_ff});
            mul_b = $signed({17'd0, wfpid_pkg::SIN_THETA_Q16});
         end
         ST_MUL_Y: begin
            mul_a = $signed({17'd0, range_far_ff});
            mul_b = $signed({17'd0, wfpid_pkg::COS_THETA_Q16});
         end
         ST_PROJ_C: begin
            mul_a = $signed({17'd0, range_near_ff});
            mul_b = x_ff[32:0];
         end
         ST_PROJ_S: begin
            mul_a = $signed({17'd0, cfg.lookahead_mm});
            mul_b = y_ff[32:0];
         end
         ST_TERM_HI: begin
            mul_a = $signed({5'd0, term_gain});
            mul_b = $signed({13'd0, term_mag[39:20]});
         end
         ST_TERM_LO: begin
            mul_a = $signed({5'd0, term_gain});
            mul_b = $signed({13'd0, term_mag[19:0]});
         end
         ST_DIV: begin
            mul_a = $signed({7'd0, div_num});
            mul_b = $signed({6'd0, wfpid_pkg::RECIP_1000});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // 16-bit quotient digit by reciprocal multiplication, then the remainder
   logic [15:0] div_q;
   logic [25:0] div_back;
   assign div_q    = mul_p[wfpid_pkg::RECIP_SHIFT+15:wfpid_pkg::RECIP_SHIFT];
   assign div_back = 26'(div_q) * 26'(wfpid_pkg::DIVISOR);

   // shared CORDIC stage
   logic signed [37:0] dx, dy;
   logic signed [26:0] ang;
   logic               cordic_last;
   assign dx          = y_ff >>> step_ff;
   assign dy          = x_ff >>> step_ff;
   assign ang         = $signed({3'd0, wfpid_pkg::atan_q24(step_ff)});
   assign cordic_last = step_ff == 5'(CORDIC_STEPS - 1);

   // error and integral update
   logic signed [51:0] err_full;
   logic signed [21:0] err_wide;
   logic signed [17:0] err_sat;
   logic signed [40:0] sum_wide;
   logic signed [39:0] sum_sat;
   always_comb begin
      err_full = acc_ff - 52'(prod_ff);
      err_wide = err_full[51:30];
      if (err_wide > 22'sd131071)       err_sat = 18'sd131071;
      else if (err_wide < -22'sd131072) err_sat = -18'sd131072;
      else                              err_sat = err_wide[17:0];
      sum_wide = 41'(error_sum_ff) + 41'(err_sat);
      if (sum_wide > 41'sd549755813887)       sum_sat = 40'sh7F_FFFF_FFFF;
      else if (sum_wide < -41'sd549755813888) sum_sat = 40'sh80_0000_0000;
      else                                    sum_sat = sum_wide[39:0];
   end

   // term scaling and cap
   logic [63:0]        scaled;
   logic [40:0]        term_abs;
   logic signed [44:0] term_signed;
   always_comb begin
      scaled = {quot_ff[47:0], 16'd0} >> GAIN_FRAC_BITS;
      if (over_ff || (quot_ff >= 64'h4000_0000_0000))
         term_abs = 41'h100_0000_0000;
      else if (scaled > 64'h100_0000_0000)
         term_abs = 41'h100_0000_0000;
      else
         term_abs = scaled[40:0];
      term_signed = neg_ff ? -$signed({4'd0, term_abs}) : $signed({4'd0, term_abs});
   end

   // output saturation and speed tier
   logic signed [18:0] steer_sat;
   logic [18:0]        steer_mag;
   logic [10:0]        speed;
   always_comb begin
      if (steer_ff > 45'sd262143)       steer_sat = 19'sd262143;
      else if (steer_ff < -45'sd262144) steer_sat = -19'sd262144;
      else                              steer_sat = steer_ff[18:0];
      steer_mag = steer_sat[18] ? 19'(-steer_sat) : 19'(steer_sat);
      priority if (steer_mag <= wfpid_pkg::SLOW_LIMIT) speed = wfpid_pkg::SPEED_FAST;
      else if (steer_mag <= wfpid_pkg::MID_LIMIT)      speed = wfpid_pkg::SPEED_MID;
      else                                             speed = wfpid_pkg::SPEED_SLOW;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_fire && req_ch.scan_last) state_in = ST_MUL_X;
         ST_MUL_X:    state_in = ST_MUL_Y;
         ST_MUL_Y:    state_in = ST_VEC_INIT;
         ST_VEC_INIT: state_in = (range_far_ff == '0 && range_near_ff == '0) ?
                                 ST_ROT_INIT : ST_VEC;
         ST_VEC:      if (cordic_last) state_in = ST_ROT_INIT;
         ST_ROT_INIT: state_in = ST_ROT;
         ST_ROT:      if (cordic_last) state_in = ST_PROJ_C;
         ST_PROJ_C:   state_in = ST_PROJ_S;
         ST_PROJ_S:   state_in = ST_ERR;
         ST_ERR:      state_in = ST_TERM_HI;
         ST_TERM_HI:  state_in = ST_TERM_LO;
         ST_TERM_LO:  state_in = ST_TERM_SUM;
         ST_TERM_SUM: state_in = (hi_ff >= 49'h400_0000_0000) ? ST_TERM_FIN : ST_DIV;
         ST_DIV:      if (chunk_ff == 2'd3) state_in = ST_TERM_FIN;
         ST_TERM_FIN: state_in = (term_ff == wfpid_pkg::TERM_D) ? ST_OUT : ST_TERM_HI;
         ST_OUT:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         range_near_ff <= '0;
         range_far_ff  <= '0;
         last_error_ff <= '0;
         error_sum_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            if (hit_near) range_near_ff <= req_ch.range_mm;
            if (hit_far)  range_far_ff  <= req_ch.range_mm;
            if (req_ch.scan_last || count_wrap) count_ff <= '0;
            else                                count_ff <= count_ff + 1'b1;
         end
         if (state_ff == ST_ERR) begin
            last_error_ff <= err_sat;
            error_sum_ff  <= sum_sat;
         end
         if (state_ff == ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready)              rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_p[50:0];
      unique case (state_ff)
         ST_MUL_Y: x_ff <= prod_ff[37:0];
         ST_VEC_INIT: begin
            y_ff    <= prod_ff[37:0] - $signed({6'd0, range_near_ff, 16'd0});
            z_ff    <= '0;
            step_ff <= '0;
         end
         ST_VEC: begin
            if (!y_ff[37]) begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + ang;
            end else begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - ang;
            end
            step_ff <= step_ff + 1'b1;
         end
         ST_ROT_INIT: begin
            x_ff    <= $signed({6'd0, wfpid_pkg::INV_GAIN_Q30});
            y_ff    <= '0;
            step_ff <= '0;
         end
         ST_ROT: begin
            if (!z_ff[26]) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - ang;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + ang;
            end
            step_ff <= step_ff + 1'b1;
         end
         ST_PROJ_S: acc_ff <= $signed({6'd0, cfg.desired_distance_mm, 30'd0})
                              + 52'sd536870912 - 52'(prod_ff);
         ST_ERR: begin
            e_ff     <= err_sat;
            diff_ff  <= 19'(err_sat) - 19'(last_error_ff);
            term_ff  <= wfpid_pkg::TERM_P;
            steer_ff <= '0;
         end
         ST_TERM_HI: neg_ff <= term_val[39];
         ST_TERM_LO: hi_ff <= prod_ff[48:0];
         ST_TERM_SUM: begin
            over_ff  <= hi_ff >= 49'h400_0000_0000;
            quot_ff  <= ({16'd0, hi_ff[47:0]} << 20) + {16'd0, prod_ff[47:0]};
            rem_ff   <= '0;
            chunk_ff <= '0;
         end
         ST_DIV: begin
            rem_ff   <= 10'(div_num - div_back);
            quot_ff  <= {quot_ff[47:0], div_q};
            chunk_ff <= chunk_ff + 1'b1;
         end
         ST_TERM_FIN: begin
            steer_ff <= steer_ff - term_signed;
            term_ff  <= term_ff + 1'b1;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_steer_ff <= steer_sat;
               rsp_speed_ff <= speed;
               rsp_error_ff <= e_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: design/wfpid_csr.sv
// APB-style register file holding the controller configuration.
// Depends on wfpid_pkg.
`default_nettype none

module wfpid_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [wfpid_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [wfpid_pkg::CSR_DATA_W-1:0]     pwdata,
   output      logic [wfpid_pkg::CSR_DATA_W-1:0]     prdata,
   output      logic                                 pready,
   output      wfpid_pkg::cfg_type                   cfg
);

   wfpid_pkg::cfg_type cfg_ff, cfg_in;
   logic               wr_en;
   logic [2:0]         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            wfpid_pkg::REG_INDEX_NEAR:   cfg_in.index_near = pwdata[10:0];
            wfpid_pkg::REG_INDEX_FAR:    cfg_in.index_far = pwdata[10:0];
            wfpid_pkg::REG_DESIRED_DIST: cfg_in.desired_distance_mm = pwdata[15:0];
            wfpid_pkg::REG_LOOKAHEAD:    cfg_in.lookahead_mm = pwdata[15:0];
            wfpid_pkg::REG_GAIN_P:       cfg_in.gain_p = pwdata[27:0];
            wfpid_pkg::REG_GAIN_I:       cfg_in.gain_i = pwdata[27:0];
            wfpid_pkg::REG_GAIN_D:       cfg_in.gain_d = pwdata[27:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.index_near          <= wfpid_pkg::INDEX_NEAR_RST;
         cfg_ff.index_far           <= wfpid_pkg::INDEX_FAR_RST;
         cfg_ff.desired_distance_mm <= wfpid_pkg::DESIRED_RST;
         cfg_ff.lookahead_mm        <= wfpid_pkg::LOOKAHEAD_RST;
         cfg_ff.gain_p              <= wfpid_pkg::GAIN_P_RST;
         cfg_ff.gain_i              <= wfpid_pkg::GAIN_I_RST;
         cfg_ff.gain_d              <= wfpid_pkg::GAIN_D_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read-back
   always_comb begin
      unique case (reg_idx)
         wfpid_pkg::REG_INDEX_NEAR:   prdata = {21'd0, cfg_ff.index_near};
         wfpid_pkg::REG_INDEX_FAR:    prdata = {21'd0, cfg_ff.index_far};
         wfpid_pkg::REG_DESIRED_DIST: prdata = {16'd0, cfg_ff.desired_distance_mm};
         wfpid_pkg::REG_LOOKAHEAD:    prdata = {16'd0, cfg_ff.lookahead_mm};
         wfpid_pkg::REG_GAIN_P:       prdata = {4'd0, cfg_ff.gain_p};
         wfpid_pkg::REG_GAIN_I:       prdata = {4'd0, cfg_ff.gain_i};
         wfpid_pkg::REG_GAIN_D:       prdata = {4'd0, cfg_ff.gain_d};
         default:                     prdata = '0;
      endcase
   end

endmodule

`default_nettype wire
